FILE: sv/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SCT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define SCT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define SCT_ASSERT(label, cond, msg)

`define SCT_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: sv/sct_pkg.sv
package sct_pkg;

	localparam int CW = 16;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_INT   = 3'd2,
		MODE_DOT   = 3'd3,
		MODE_HALT  = 3'd4
	} mode_t;

	localparam logic [3:0] K_IDENT  = 4'd0;
	localparam logic [3:0] K_INT    = 4'd1;
	localparam logic [3:0] K_DOT    = 4'd2;
	localparam logic [3:0] K_COLON  = 4'd3;
	localparam logic [3:0] K_SEMI   = 4'd4;
	localparam logic [3:0] K_LPAREN = 4'd5;
	localparam logic [3:0] K_RPAREN = 4'd6;
	localparam logic [3:0] K_LBRACK = 4'd7;
	localparam logic [3:0] K_RBRACK = 4'd8;
	localparam logic [3:0] K_LBRACE = 4'd9;
	localparam logic [3:0] K_RBRACE = 4'd10;
	localparam logic [3:0] K_EOF    = 4'd11;
	localparam logic [3:0] K_BAD    = 4'd12;
	localparam logic [3:0] K_FLOAT  = 4'd13;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_LBRACK     = 8'h5B;
	localparam logic [7:0] CH_RBRACK     = 8'h5D;
	localparam logic [7:0] CH_LBRACE     = 8'h7B;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;

	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] start_pos;
		logic [15:0] token_length;
		logic [15:0] start_row;
		logic [15:0] start_column;
		logic [7:0]  offending_byte;
		logic        last_of_run;
	} token_t;

	function automatic cnt_t sat_inc(cnt_t v);
		return (&v) ? v : v + CW'(1);
	endfunction

	function automatic logic [15:0] clamp16(cnt_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic token_t make_tok(logic [3:0] kind, cnt_t pos, cnt_t len,
		cnt_t line, cnt_t col, logic [7:0] bad);
		token_t t;
		t.token_kind     = kind;
		t.start_pos      = clamp16(pos);
		t.token_length   = clamp16(len);
		t.start_row      = clamp16(line);
		t.start_column   = clamp16(col);
		t.offending_byte = bad;
		t.last_of_run    = 1'b0;
		return t;
	endfunction

endpackage

FILE: sv/sct_src_if.sv
interface sct_src_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] char_byte;

	modport source (output valid, output action, output char_byte, input ready);
	modport sink (input valid, input action, input char_byte, output ready);
endinterface

FILE: sv/sct_tok_if.sv
interface sct_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] start_pos;
	logic [15:0] token_length;
	logic [15:0] start_row;
	logic [15:0] start_column;
	logic [7:0]  offending_byte;
	logic        last_of_run;

	modport source (output valid, output token_kind, output start_pos, output token_length,
		output start_row, output start_column, output offending_byte,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input start_pos, input token_length,
		input start_row, input start_column, input offending_byte,
		input last_of_run, output ready);
endinterface

FILE: sv/source_char_tokenizer_core.sv
// flow: a word is registered in s1 on acceptance; its tokens enter the output queue when
// it leaves s1, and the first token is then offered at the queue head
// throughput: one input word per cycle; a word waits in s1 while the queue holds more
// than two tokens; the 4-entry queue drains one token per cycle while tok.ready is high
// reset: arst_n clears scan state, counters and the queue; no token is pending after reset
`include "assert_macros.svh"

module source_char_tokenizer_core import sct_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sct_src_if.sink       src,
	sct_tok_if.source     tok
);

	logic       v_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	mode_t mode_q, n_mode;
	cnt_t  pos_q, line_q, col_q, tpos_q, tline_q, tcol_q, len_q;
	cnt_t  n_pos, n_line, n_col, n_tpos, n_tline, n_tcol, n_len;

	token_t           q_mem [QDEPTH];
	logic [QAW-1:0]   head_q, tail_q;
	logic [QAW:0]     cnt_q;

	logic   room, fire, pop;
	logic   cl_v, nw_v, do_idle, adv;
	token_t cl_tok, nw_tok, res0, res1;
	logic [1:0] push_n;

	logic is_letter, is_digit, is_space, is_punct;
	logic [3:0] pk;

	assign room = cnt_q <= (QAW+1)'(QDEPTH - 2);
	assign fire = v_s1 && room;
	assign src.ready = !v_s1 || room;
	assign pop = tok.valid && tok.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src.ready) begin
			v_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			action_s1 <= src.action;
			byte_s1   <= src.char_byte;
		end
	end

	// byte classes
	always_comb begin
		is_letter = (byte_s1 >= 8'h61 && byte_s1 <= 8'h7A) ||
			(byte_s1 >= 8'h41 && byte_s1 <= 8'h5A) || byte_s1 == CH_UNDERSCORE;
		is_digit  = byte_s1 >= 8'h30 && byte_s1 <= 8'h39;
		is_space  = byte_s1 == CH_SPACE || byte_s1 == CH_TAB || byte_s1 == CH_NEWLINE;
		is_punct  = 1'b1;
		unique case (byte_s1)
			CH_COLON:  pk = K_COLON;
			CH_SEMI:   pk = K_SEMI;
			CH_LPAREN: pk = K_LPAREN;
			CH_RPAREN: pk = K_RPAREN;
			CH_LBRACK: pk = K_LBRACK;
			CH_RBRACK: pk = K_RBRACK;
			CH_LBRACE: pk = K_LBRACE;
			CH_RBRACE: pk = K_RBRACE;
			default: begin
				pk = K_BAD;
				is_punct = 1'b0;
			end
		endcase
	end

	// next scan state and tokens of the word in s1
	always_comb begin
		n_mode  = mode_q;
		n_pos   = pos_q;
		n_line  = line_q;
		n_col   = col_q;
		n_tpos  = tpos_q;
		n_tline = tline_q;
		n_tcol  = tcol_q;
		n_len   = len_q;
		cl_v    = 1'b0;
		nw_v    = 1'b0;
		cl_tok  = '0;
		nw_tok  = '0;
		do_idle = 1'b0;
		adv     = 1'b0;

		if (mode_q == MODE_HALT) begin
			n_mode = MODE_HALT;
		end else if (action_s1) begin
			unique case (mode_q)
				MODE_IDENT: begin
					cl_v   = 1'b1;
					cl_tok = make_tok(K_IDENT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
				end
				MODE_INT: begin
					cl_v   = 1'b1;
					cl_tok = make_tok(K_INT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
				end
				MODE_DOT: begin
					cl_v   = 1'b1;
					cl_tok = make_tok(K_DOT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
				end
				default: cl_v = 1'b0;
			endcase
			nw_v    = 1'b1;
			nw_tok  = make_tok(K_EOF, pos_q, '0, line_q, col_q, 8'h00);
			n_mode  = MODE_IDLE;
			n_pos   = '0;
			n_line  = '0;
			n_col   = '0;
			n_tpos  = '0;
			n_tline = '0;
			n_tcol  = '0;
			n_len   = '0;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_letter || is_digit) begin
						n_len = sat_inc(len_q);
						adv   = 1'b1;
					end else begin
						cl_v    = 1'b1;
						cl_tok  = make_tok(K_IDENT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
						do_idle = 1'b1;
					end
				end
				MODE_INT: begin
					if (is_digit) begin
						n_len = sat_inc(len_q);
						adv   = 1'b1;
					end else if (byte_s1 == CH_DOT) begin
						nw_v   = 1'b1;
						nw_tok = make_tok(K_FLOAT, tpos_q, sat_inc(len_q), tline_q, tcol_q,
							8'h00);
						n_mode = MODE_HALT;
					end else begin
						cl_v    = 1'b1;
						cl_tok  = make_tok(K_INT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
						do_idle = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit) begin
						nw_v   = 1'b1;
						nw_tok = make_tok(K_FLOAT, tpos_q, CW'(2), tline_q, tcol_q, 8'h00);
						n_mode = MODE_HALT;
					end else begin
						cl_v    = 1'b1;
						cl_tok  = make_tok(K_DOT, tpos_q, len_q, tline_q, tcol_q, 8'h00);
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			if (do_idle) begin
				n_mode = MODE_IDLE;
				adv    = 1'b1;
				if (!is_space) begin
					n_tpos  = pos_q;
					n_tline = line_q;
					n_tcol  = col_q;
					n_len   = '0;
					priority if (is_letter) begin
						n_mode = MODE_IDENT;
						n_len  = CW'(1);
					end else if (is_digit) begin
						n_mode = MODE_INT;
						n_len  = CW'(1);
					end else if (byte_s1 == CH_DOT) begin
						n_mode = MODE_DOT;
						n_len  = CW'(1);
					end else if (is_punct) begin
						nw_v   = 1'b1;
						nw_tok = make_tok(pk, pos_q, CW'(1), line_q, col_q, 8'h00);
					end else begin
						nw_v   = 1'b1;
						nw_tok = make_tok(K_BAD, pos_q, CW'(1), line_q, col_q, byte_s1);
						n_mode = MODE_HALT;
						adv    = 1'b0;
					end
				end
			end

			if (adv) begin
				n_pos = sat_inc(pos_q);
				if (byte_s1 == CH_NEWLINE) begin
					n_line = sat_inc(line_q);
					n_col  = '0;
				end else begin
					n_col = sat_inc(col_q);
				end
			end
		end
	end

	// pack the closed token ahead of the new one
	always_comb begin
		push_n = 2'(cl_v) + 2'(nw_v);
		res0   = cl_v ? cl_tok : nw_tok;
		res1   = nw_tok;
		res0.last_of_run = (push_n == 2'd1);
		res1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			line_q  <= '0;
			col_q   <= '0;
			tpos_q  <= '0;
			tline_q <= '0;
			tcol_q  <= '0;
			len_q   <= '0;
		end else if (fire) begin
			mode_q  <= n_mode;
			pos_q   <= n_pos;
			line_q  <= n_line;
			col_q   <= n_col;
			tpos_q  <= n_tpos;
			tline_q <= n_tline;
			tcol_q  <= n_tcol;
			len_q   <= n_len;
		end
	end

	// token queue
	always_ff @(posedge clk) begin
		if (fire && push_n != 2'd0) begin
			q_mem[tail_q] <= res0;
		end
		if (fire && push_n == 2'd2) begin
			q_mem[tail_q + QAW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (fire) begin
				tail_q <= tail_q + QAW'(push_n);
			end
			if (pop) begin
				head_q <= head_q + QAW'(1);
			end
			cnt_q <= cnt_q + (fire ? (QAW+1)'(push_n) : '0) - (QAW+1)'(pop);
		end
	end

	assign tok.valid          = cnt_q != '0;
	assign tok.token_kind     = q_mem[head_q].token_kind;
	assign tok.start_pos      = q_mem[head_q].start_pos;
	assign tok.token_length   = q_mem[head_q].token_length;
	assign tok.start_row      = q_mem[head_q].start_row;
	assign tok.start_column   = q_mem[head_q].start_column;
	assign tok.offending_byte = q_mem[head_q].offending_byte;
	assign tok.last_of_run    = q_mem[head_q].last_of_run;

	`SCT_ASSERT(a_queue_bound, cnt_q <= (QAW+1)'(QDEPTH), "token queue overflow")
	`SCT_ASSERT_NEXT(a_halt_sticks, mode_q == MODE_HALT, mode_q == MODE_HALT, "left halt without reset")
	`SCT_ASSERT(a_room_on_fire, !fire || cnt_q <= (QAW+1)'(QDEPTH - 2), "push without room")

endmodule
